>>> sv/fir_ema_pkg.sv
// ----------------------------------------------------------------------------
// fir_ema_pkg
// Shared types, register map and rounding helper for the block FIR
// decimator with EMA offset tracking.
// ----------------------------------------------------------------------------
package fir_ema_pkg;

   localparam int SampleW = 16;
   localparam int AccW    = 40;
   localparam int ProdW   = 32;
   localparam int WeightW = 15;
   localparam int MvW     = 12;
   localparam int CsrDataW = 64;
   localparam int CsrAddrW = 6;

   localparam logic [CsrDataW-1:0] CoeffReset  = 64'h0800_0800_0800_0800;
   localparam logic [WeightW-1:0]  WeightReset = 15'd16384;
   localparam logic signed [SampleW-1:0] MvScale = 16'sd1650;
   localparam logic signed [16:0]        MvMid   = 17'sd1650;

   typedef enum logic [2:0] {
      REG_COEFF_0  = 3'd0,
      REG_COEFF_1  = 3'd1,
      REG_COEFF_2  = 3'd2,
      REG_COEFF_3  = 3'd3,
      REG_W_NEW    = 3'd4,
      REG_W_OLD    = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_RND,
      ST_EMA_NEW,
      ST_EMA_OLD,
      ST_EMA_SUM,
      ST_EMA_RND,
      ST_MV_MUL,
      ST_MV_ADD,
      ST_OUT
   } state_type;

   // Round Q30 to Q15 (add half, floor shift) and saturate to 16 bits.
   function automatic logic signed [SampleW-1:0] round_sat_q15(
      input logic signed [AccW-1:0] v
   );
      logic signed [AccW-1:0] t;
      logic signed [SampleW-1:0] r;
      t = (v + 40'sd16384) >>> 15;
      if (t > 40'sd32767) begin
         r = 16'sh7FFF;
      end else if (t < -40'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = t[SampleW-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/fir_ema_if.sv
// ----------------------------------------------------------------------------
// fir_ema_req_if / fir_ema_rsp_if
// Valid/ready channels carrying samples in and filtered results out.
// ----------------------------------------------------------------------------
interface fir_ema_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fir_ema_pkg::SampleW-1:0] sample;
   logic                                   motor_floating;

   modport source (output valid, output sample, output motor_floating, input ready);
   modport sink   (input valid, input sample, input motor_floating, output ready);
endinterface

interface fir_ema_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [fir_ema_pkg::SampleW-1:0] filtered;
   logic signed [fir_ema_pkg::SampleW-1:0] offset;
   logic [fir_ema_pkg::MvW-1:0]            sensor_millivolts;

   modport source (output valid, output filtered, output offset,
                   output sensor_millivolts, input ready);
   modport sink   (input valid, input filtered, input offset,
                   input sensor_millivolts, output ready);
endinterface

>>> sv/block_fir_decimator_with_ema_offset_top.sv
// ----------------------------------------------------------------------------
// block_fir_decimator_with_ema_offset_top
// Q15 block FIR decimator with EMA offset tracking and millivolt scaling,
// built around one shared 16x16 signed multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_bus   in         valid/ready         sample, motor_floating
//  rsp_bus   out        valid/ready         filtered, offset, sensor_millivolts
//  csr_*     in/out     APB, pready high    coefficients, EMA weights
//
//  A sample is accepted, multiplied and accumulated; ready is low while
//  it is in flight. The last sample of a block adds a rounding step, the
//  EMA update when motor_floating is set (new and old weight products, sum,
//  rounding), millivolt scaling (multiply, add) and a load of the output
//  register. Every product goes through the single multiplier. A result
//  waiting in the output register does not block new samples; the sequencer
//  only waits before loading the next result. Reset is synchronous and
//  restores the register defaults and clears the block.
// ----------------------------------------------------------------------------
module block_fir_decimator_with_ema_offset_top #(
   parameter int TAPS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fir_ema_req_if.sink                          req_bus,
   fir_ema_rsp_if.source                        rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fir_ema_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [fir_ema_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [fir_ema_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int TapW = (TAPS > 1) ? $clog2(TAPS) : 1;

   // configuration
   logic [fir_ema_pkg::CsrDataW-1:0] coeff0_ff, coeff1_ff, coeff2_ff, coeff3_ff;
   logic [fir_ema_pkg::WeightW-1:0]  w_new_ff, w_old_ff;
   logic                             csr_wr;
   logic [2:0]                       csr_idx;

   // datapath
   fir_ema_pkg::state_type                 state_ff, state_in;
   logic [TapW-1:0]                        tap_ff, tap_in;
   logic signed [fir_ema_pkg::AccW-1:0]    acc_ff, acc_in;
   logic signed [fir_ema_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic signed [fir_ema_pkg::SampleW-1:0] sample_ff, sample_in;
   logic                                   float_ff, float_in;
   logic signed [fir_ema_pkg::SampleW-1:0] filt_ff, filt_in;
   logic signed [fir_ema_pkg::SampleW-1:0] offset_ff, offset_in;
   logic [fir_ema_pkg::MvW-1:0]            mv_ff, mv_in;

   // output register
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [fir_ema_pkg::SampleW-1:0] rsp_filt_ff, rsp_filt_in;
   logic signed [fir_ema_pkg::SampleW-1:0] rsp_off_ff, rsp_off_in;
   logic [fir_ema_pkg::MvW-1:0]            rsp_mv_ff, rsp_mv_in;

   // shared multiplier
   logic signed [fir_ema_pkg::SampleW-1:0] mul_a, mul_b;
   logic signed [fir_ema_pkg::SampleW-1:0] coeff_sel;
   logic [3:0]                             tap4;
   logic [fir_ema_pkg::CsrDataW-1:0]       coeff_word;
   logic signed [16:0]                     mv_sum;
   logic signed [fir_ema_pkg::AccW-1:0]    prod_ext;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff0_ff <= fir_ema_pkg::CoeffReset;
         coeff1_ff <= fir_ema_pkg::CoeffReset;
         coeff2_ff <= fir_ema_pkg::CoeffReset;
         coeff3_ff <= fir_ema_pkg::CoeffReset;
         w_new_ff  <= fir_ema_pkg::WeightReset;
         w_old_ff  <= fir_ema_pkg::WeightReset;
      end else if (csr_wr) begin
         case (csr_idx)
            fir_ema_pkg::REG_COEFF_0: coeff0_ff <= csr_pwdata;
            fir_ema_pkg::REG_COEFF_1: coeff1_ff <= csr_pwdata;
            fir_ema_pkg::REG_COEFF_2: coeff2_ff <= csr_pwdata;
            fir_ema_pkg::REG_COEFF_3: coeff3_ff <= csr_pwdata;
            fir_ema_pkg::REG_W_NEW:   w_new_ff  <= csr_pwdata[fir_ema_pkg::WeightW-1:0];
            fir_ema_pkg::REG_W_OLD:   w_old_ff  <= csr_pwdata[fir_ema_pkg::WeightW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         fir_ema_pkg::REG_COEFF_0: csr_prdata = coeff0_ff;
         fir_ema_pkg::REG_COEFF_1: csr_prdata = coeff1_ff;
         fir_ema_pkg::REG_COEFF_2: csr_prdata = coeff2_ff;
         fir_ema_pkg::REG_COEFF_3: csr_prdata = coeff3_ff;
         fir_ema_pkg::REG_W_NEW:   csr_prdata = {49'd0, w_new_ff};
         fir_ema_pkg::REG_W_OLD:   csr_prdata = {49'd0, w_old_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------- coefficient select ----------------
   assign tap4 = 4'(tap_ff);

   always_comb begin
      case (tap4[3:2])
         2'd0:    coeff_word = coeff0_ff;
         2'd1:    coeff_word = coeff1_ff;
         2'd2:    coeff_word = coeff2_ff;
         default: coeff_word = coeff3_ff;
      endcase
      case (tap4[1:0])
         2'd0:    coeff_sel = coeff_word[15:0];
         2'd1:    coeff_sel = coeff_word[31:16];
         2'd2:    coeff_sel = coeff_word[47:32];
         default: coeff_sel = coeff_word[63:48];
      endcase
   end

   assign prod_ext = {{(fir_ema_pkg::AccW - fir_ema_pkg::ProdW){prod_ff[31]}}, prod_ff};
   // 1650 + floor(prod / 2^15), 0..3299 when prod holds the millivolt product
   assign mv_sum   = prod_ff[31:15] + fir_ema_pkg::MvMid;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_ema_pkg::ST_IDLE;
         tap_ff       <= '0;
         acc_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         acc_ff       <= acc_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      sample_ff   <= sample_in;
      float_ff    <= float_in;
      filt_ff     <= filt_in;
      mv_ff       <= mv_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_mv_ff   <= rsp_mv_in;
   end

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      acc_in       = acc_ff;
      sample_in    = sample_ff;
      float_in     = float_ff;
      filt_in      = filt_ff;
      offset_in    = offset_ff;
      mv_in        = mv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_mv_in    = rsp_mv_ff;
      mul_a        = sample_ff;
      mul_b        = coeff_sel;
      req_bus.ready = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         fir_ema_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
               float_in  = req_bus.motor_floating;
               state_in  = fir_ema_pkg::ST_MUL;
            end
         end
         fir_ema_pkg::ST_MUL: begin
            state_in = fir_ema_pkg::ST_ACC;
         end
         fir_ema_pkg::ST_ACC: begin
            acc_in = acc_ff + prod_ext;
            if (tap_ff == TapW'(TAPS - 1)) begin
               state_in = fir_ema_pkg::ST_RND;
            end else begin
               tap_in   = tap_ff + 1'b1;
               state_in = fir_ema_pkg::ST_IDLE;
            end
         end
         fir_ema_pkg::ST_RND: begin
            filt_in  = fir_ema_pkg::round_sat_q15(acc_ff);
            acc_in   = '0;
            tap_in   = '0;
            state_in = float_ff ? fir_ema_pkg::ST_EMA_NEW : fir_ema_pkg::ST_MV_MUL;
         end
         fir_ema_pkg::ST_EMA_NEW: begin
            mul_a    = filt_ff;
            mul_b    = {1'b0, w_new_ff};
            state_in = fir_ema_pkg::ST_EMA_OLD;
         end
         fir_ema_pkg::ST_EMA_OLD: begin
            acc_in   = prod_ext;
            mul_a    = offset_ff;
            mul_b    = {1'b0, w_old_ff};
            state_in = fir_ema_pkg::ST_EMA_SUM;
         end
         fir_ema_pkg::ST_EMA_SUM: begin
            acc_in   = acc_ff + prod_ext;
            state_in = fir_ema_pkg::ST_EMA_RND;
         end
         fir_ema_pkg::ST_EMA_RND: begin
            offset_in = fir_ema_pkg::round_sat_q15(acc_ff);
            acc_in    = '0;
            state_in  = fir_ema_pkg::ST_MV_MUL;
         end
         fir_ema_pkg::ST_MV_MUL: begin
            mul_a    = filt_ff;
            mul_b    = fir_ema_pkg::MvScale;
            state_in = fir_ema_pkg::ST_MV_ADD;
         end
         fir_ema_pkg::ST_MV_ADD: begin
            mv_in    = mv_sum[fir_ema_pkg::MvW-1:0];
            state_in = fir_ema_pkg::ST_OUT;
         end
         fir_ema_pkg::ST_OUT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = filt_ff;
               rsp_off_in   = offset_ff;
               rsp_mv_in    = mv_ff;
               state_in     = fir_ema_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fir_ema_pkg::ST_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.filtered          = rsp_filt_ff;
   assign rsp_bus.offset            = rsp_off_ff;
   assign rsp_bus.sensor_millivolts = rsp_mv_ff;

endmodule

>>> bench/tb_block_fir_decimator_with_ema_offset_top.sv
// ----------------------------------------------------------------------------
// tb_block_fir_decimator_with_ema_offset_top
// Self-checking bench for the block FIR decimator with EMA offset tracking.
// Samples go in from a queue through a valid/ready driver. Each accepted
// sample is run through a local fixed-point model of the filter. The model
// holds the coefficients, weights, accumulator, tap position and offset.
// Each result transaction is compared field by field with the oldest
// predicted block. The APB registers are written and read back between
// phases, sometimes mid-block. The idle profiles change between phases, and
// once the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_block_fir_decimator_with_ema_offset_top;

   localparam int Taps         = 16;
   localparam int HalfPeriod   = 2;
   localparam int SettleCycles = 20;
   localparam int HoldCycles   = 300;
   localparam int RandomPhases = 12;
   localparam logic [2:0] RegSpare6 = 3'd6;
   localparam logic [2:0] RegSpare7 = 3'd7;
   localparam int HeadVals [8] = '{32767, -32768, 0, -1, 1, 32767, 32767, -32768};
   localparam int TailVals [8] = '{-32768, -32768, 16384, -16384, 32767, -32768, 1, -1};

   typedef struct packed {
      logic signed [fir_ema_pkg::SampleW-1:0] sample;
      logic                                   motor_floating;
   } adc_sample_type;

   typedef struct packed {
      logic signed [fir_ema_pkg::SampleW-1:0] filtered;
      logic signed [fir_ema_pkg::SampleW-1:0] offset;
      logic [fir_ema_pkg::MvW-1:0]            millivolts;
   } block_result_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [fir_ema_pkg::CsrAddrW-1:0] csr_paddr   = '0;
   logic [fir_ema_pkg::CsrDataW-1:0] csr_pwdata  = '0;
   logic [fir_ema_pkg::CsrDataW-1:0] csr_prdata;
   logic                             csr_pready;

   fir_ema_req_if req_bus ();
   fir_ema_rsp_if rsp_bus ();

   block_fir_decimator_with_ema_offset_top #(.TAPS(Taps)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HalfPeriod clock = ~clock;

   // Model of the block
   logic [fir_ema_pkg::CsrDataW-1:0]       coeff_bank [4];
   logic [fir_ema_pkg::WeightW-1:0]        weight_new;
   logic [fir_ema_pkg::WeightW-1:0]        weight_old;
   longint                                 mac_sum;
   int                                     tap_index;
   logic signed [fir_ema_pkg::SampleW-1:0] offset_track;

   adc_sample_type   sample_queue [$];
   block_result_type expected_blocks [$];

   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   logic sample_taken = 1'b0;
   logic hold_request = 1'b0;
   logic rsp_hold     = 1'b0;

   int mismatches       = 0;
   int samples_sent     = 0;
   int blocks_checked   = 0;
   int saturated_blocks = 0;
   int ema_updates      = 0;
   int csr_writes       = 0;

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic void fir_model_reset();
      for (int r = 0; r < 4; r++) begin
         coeff_bank[r] = fir_ema_pkg::CoeffReset;
      end
      weight_new   = fir_ema_pkg::WeightReset;
      weight_old   = fir_ema_pkg::WeightReset;
      mac_sum      = 0;
      tap_index    = 0;
      offset_track = '0;
   endfunction

   function automatic void fir_model_config(logic [2:0] index,
                                            logic [fir_ema_pkg::CsrDataW-1:0] value);
      case (index)
         fir_ema_pkg::REG_COEFF_0, fir_ema_pkg::REG_COEFF_1,
         fir_ema_pkg::REG_COEFF_2, fir_ema_pkg::REG_COEFF_3: coeff_bank[index[1:0]] = value;
         fir_ema_pkg::REG_W_NEW: weight_new = value[fir_ema_pkg::WeightW-1:0];
         fir_ema_pkg::REG_W_OLD: weight_old = value[fir_ema_pkg::WeightW-1:0];
         default: ;  // unmapped index, write dropped
      endcase
   endfunction

   function automatic logic [fir_ema_pkg::CsrDataW-1:0] model_register(logic [2:0] index);
      case (index)
         fir_ema_pkg::REG_W_NEW:
            return {{(fir_ema_pkg::CsrDataW-fir_ema_pkg::WeightW){1'b0}}, weight_new};
         fir_ema_pkg::REG_W_OLD:
            return {{(fir_ema_pkg::CsrDataW-fir_ema_pkg::WeightW){1'b0}}, weight_old};
         default:   return coeff_bank[index[1:0]];
      endcase
   endfunction

   function automatic logic signed [fir_ema_pkg::SampleW-1:0] tap_coeff(int tap);
      logic [fir_ema_pkg::CsrDataW-1:0] word;
      word = coeff_bank[tap / 4];
      return word[(tap % 4) * 16 +: 16];
   endfunction

   // Q30 -> Q15: add half an LSB, floor shift, clamp
   function automatic logic signed [fir_ema_pkg::SampleW-1:0] q30_to_q15_sat(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return r[fir_ema_pkg::SampleW-1:0];
   endfunction

   function automatic void fir_model_step(adc_sample_type item);
      block_result_type res;
      longint           ema;
      longint           mv;
      longint           unclamped;
      mac_sum += longint'($signed(item.sample)) * longint'(tap_coeff(tap_index));
      if (tap_index != Taps - 1) begin
         tap_index++;
         return;
      end
      unclamped = (mac_sum + 16384) >>> 15;
      if (unclamped > 32767 || unclamped < -32768) saturated_blocks++;
      res.filtered = q30_to_q15_sat(mac_sum);
      mac_sum   = 0;
      tap_index = 0;
      if (item.motor_floating) begin
         ema = longint'(weight_new) * longint'($signed(res.filtered))
             + longint'(weight_old) * longint'(offset_track);
         offset_track = q30_to_q15_sat(ema);
         ema_updates++;
      end
      res.offset = offset_track;
      mv = 1650 + ((longint'(1650) * longint'($signed(res.filtered))) >>> 15);
      res.millivolts = mv[fir_ema_pkg::MvW-1:0];
      expected_blocks.push_back(res);
   endfunction

   // Sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         sample_taken = 1'b0;
      end else if (!req_bus.valid || sample_taken) begin
         sample_taken = 1'b0;
         if (sample_queue.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            req_bus.valid          <= 1'b1;
            req_bus.sample         <= sample_queue[0].sample;
            req_bus.motor_floating <= sample_queue[0].motor_floating;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         fir_model_step(sample_queue.pop_front());
         sample_taken = 1'b1;
         samples_sent++;
      end
   end

   // Result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      wait (hold_request);
      rsp_hold = 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold     = 1'b0;
      hold_request = 1'b0;
   end

   // Result monitor
   always @(posedge clock) begin
      block_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected result, filtered", 64'($unsigned(rsp_bus.filtered)),
                            64'd0);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_bus.filtered !== want.filtered)
               report_mismatch("filtered", 64'($unsigned(rsp_bus.filtered)),
                               64'($unsigned(want.filtered)));
            if (rsp_bus.offset !== want.offset)
               report_mismatch("offset", 64'($unsigned(rsp_bus.offset)),
                               64'($unsigned(want.offset)));
            if (rsp_bus.sensor_millivolts !== want.millivolts)
               report_mismatch("sensor_millivolts", 64'(rsp_bus.sensor_millivolts),
                               64'(want.millivolts));
            blocks_checked++;
         end
      end
   end

   task automatic csr_write(logic [2:0] index, logic [fir_ema_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      fir_model_config(index, value);
      csr_writes++;
   endtask

   task automatic csr_check(logic [2:0] index);
      logic [fir_ema_pkg::CsrDataW-1:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      want = model_register(index);
      if (csr_prdata !== want) report_mismatch("register read", csr_prdata, want);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Wait for the pipeline to empty; partial blocks give no result, so settle too
   task automatic drain_and_settle();
      while (sample_queue.size() != 0 || expected_blocks.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic adc_sample_type random_sample();
      adc_sample_type s;
      case ($urandom_range(7))
         0: s.sample = 16'sh7FFF;
         1: s.sample = 16'sh8000;
         default: s.sample = 16'($urandom);
      endcase
      s.motor_floating = 1'($urandom_range(1));
      return s;
   endfunction

   // Mostly modest taps so the sum does not always clip
   function automatic logic [15:0] random_tap();
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'($urandom_range(4095) - 2048);
   endfunction

   task automatic program_phase(int p);
      logic [fir_ema_pkg::CsrDataW-1:0] word;
      logic [fir_ema_pkg::CsrDataW-1:0] w_new;
      logic [fir_ema_pkg::CsrDataW-1:0] w_old;
      for (int r = fir_ema_pkg::REG_COEFF_0; r <= fir_ema_pkg::REG_COEFF_3; r++) begin
         case (p)
            0: word = {4{16'h7FFF}};
            1: word = {4{16'h8000}};
            2: word = '0;
            default: for (int t = 0; t < 4; t++) word[t*16 +: 16] = random_tap();
         endcase
         csr_write(3'(r), word);
      end
      case (p)
         0: begin
            w_new = '1;
            w_old = '1;
         end
         1: begin
            w_new = '0;
            w_old = '0;
         end
         2: begin
            w_new = '0;
            w_old = 64'd32767;
         end
         default: begin
            w_new = 64'($urandom_range(32767));
            w_old = $urandom_range(1) ? 64'(32767 - w_new) : 64'($urandom_range(32767));
            // junk above the register width
            if ($urandom_range(3) == 0)
               w_new[fir_ema_pkg::CsrDataW-1:fir_ema_pkg::WeightW] =
                  (fir_ema_pkg::CsrDataW-fir_ema_pkg::WeightW)'({$urandom, $urandom});
            if ($urandom_range(3) == 0)
               w_old[fir_ema_pkg::CsrDataW-1:fir_ema_pkg::WeightW] =
                  (fir_ema_pkg::CsrDataW-fir_ema_pkg::WeightW)'({$urandom, $urandom});
         end
      endcase
      csr_write(fir_ema_pkg::REG_W_NEW, w_new);
      csr_write(fir_ema_pkg::REG_W_OLD, w_old);
      if ($urandom_range(3) == 0)
         csr_write($urandom_range(1) ? RegSpare6 : RegSpare7, {$urandom, $urandom});
      for (int r = fir_ema_pkg::REG_COEFF_0; r <= fir_ema_pkg::REG_W_OLD; r++)
         csr_check(3'(r));
   endtask

   initial begin
      int item_count;

      req_bus.valid          = 1'b0;
      req_bus.sample         = '0;
      req_bus.motor_floating = 1'b0;
      rsp_bus.ready          = 1'b0;
      fir_model_reset();
      req_idle_pct = 11;
      rsp_idle_pct = 77;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Half a block on the reset coefficients, then retune the upper taps mid-block
      for (int i = 0; i < 8; i++)
         sample_queue.push_back('{sample: 16'(HeadVals[i]), motor_floating: 1'(i % 2)});
      drain_and_settle();
      csr_write(fir_ema_pkg::REG_COEFF_2, 64'h7FFF_8000_0001_FFFF);
      csr_write(fir_ema_pkg::REG_COEFF_3, 64'h8000_7FFF_FFFF_0000);
      csr_write(fir_ema_pkg::REG_W_NEW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(fir_ema_pkg::REG_W_OLD, 64'h0000_0001_0000_7FFF);
      csr_write(RegSpare6, 64'hDEAD_BEEF_0123_4567);
      csr_write(RegSpare7, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int r = fir_ema_pkg::REG_COEFF_0; r <= fir_ema_pkg::REG_W_OLD; r++)
         csr_check(3'(r));
      for (int i = 0; i < 8; i++)
         sample_queue.push_back('{sample: 16'(TailVals[i]), motor_floating: 1'(i == 7)});
      drain_and_settle();

      for (int p = 0; p < RandomPhases; p++) begin
         if (p == RandomPhases / 3) begin
            req_idle_pct = 77;
            rsp_idle_pct = 11;
         end else if (p == 2 * RandomPhases / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         program_phase(p);
         // long receiver stall while samples keep coming
         if (p == RandomPhases - 2) hold_request = 1'b1;
         item_count = $urandom_range(100, 140);
         for (int i = 0; i < item_count; i++) sample_queue.push_back(random_sample());
         drain_and_settle();
      end

      $display("Run covered %0d samples and %0d result blocks (%0d clipped, %0d offset updates)",
               samples_sent, blocks_checked, saturated_blocks, ema_updates);
      $display("over %0d register writes in %0d configurations, %0d mismatches",
               csr_writes, RandomPhases + 2, mismatches);
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/fir_ema_pkg.sv
sv/fir_ema_if.sv
sv/block_fir_decimator_with_ema_offset_top.sv
bench/tb_block_fir_decimator_with_ema_offset_top.sv
